>>> hdl/cdla_pkg.sv
// ----------------------------------------------------------------------------
// cdla_pkg
// shared types and constants of the word cache: field widths, codes and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package cdla_pkg;

    localparam int ADDR_W  = 8;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 32;
    localparam int LUSED_W = 2;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOR = 1'b1;

    // mapping modes
    localparam logic MODE_DIRECT = 1'b0;
    localparam logic MODE_ASSOC  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the request
        logic look;     // tag lookup and victim pre-selection
        logic scan;     // one step of the lru scan
        logic commit;   // update lines, counters, memory and result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;  // associative miss with every line valid
        logic scan_last;  // scan is at the last line
        logic out_free;   // result register can take a new item
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/cdla_ram.sv
// ----------------------------------------------------------------------------
// cdla_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cdla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/cdla_ctrl.sv
// ----------------------------------------------------------------------------
// cdla_ctrl
// request sequencer: accept, lookup, optional lru scan, commit
// ----------------------------------------------------------------------------
`default_nettype none

module cdla_ctrl
    import cdla_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = i_sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.look   = (r_state == S_LOOK);
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_DONE) && i_sts.out_free;

endmodule

`default_nettype wire

>>> hdl/cdla_dp.sv
// ----------------------------------------------------------------------------
// cdla_dp
// cache datapath: line store, lookup, lru scan, counters, backing memory and
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module cdla_dp
    import cdla_pkg::*;
#(
    parameter int LINES     = 4,
    parameter int MEM_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_mode,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic                i_req_type,
    input  wire logic [ADDR_W-1:0]   i_address,
    input  wire logic [WORD_W-1:0]   i_store_value,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [WORD_W-1:0]        o_read_data,
    output logic                     o_hit,
    output logic                     o_status,
    output logic [LUSED_W-1:0]       o_line_used,
    output logic [COUNT_W-1:0]       o_hit_count,
    output logic [COUNT_W-1:0]       o_miss_count
);

    localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // line store
    logic                r_valid [LINES];
    logic [ADDR_W-1:0]   r_tag   [LINES];
    logic [WORD_W-1:0]   r_word  [LINES];
    logic [COUNT_W-1:0]  r_stamp [LINES];

    logic                r_mode;
    logic [COUNT_W-1:0]  r_use;
    logic [COUNT_W-1:0]  r_hits;
    logic [COUNT_W-1:0]  r_misses;

    // captured request and lookup result
    logic                r_type;
    logic [ADDR_W-1:0]   r_addr;
    logic [WORD_W-1:0]   r_value;
    logic                r_hit;
    logic                r_oor;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_cnt;
    logic [COUNT_W-1:0]  r_best;

    // backing memory, entries not yet stored read as address times ten
    logic [MEM_DEPTH-1:0] r_written;
    logic [WORD_W-1:0]    w_mem_rdata;
    logic                 w_mem_we;

    // address modulo line count, worked out at elaboration
    logic [IW-1:0] w_mod_tab [MEM_DEPTH];
    for (genvar g = 0; g < MEM_DEPTH; g++) begin : g_mod
        assign w_mod_tab[g] = IW'(g % LINES);
    end

    // lookup
    logic                w_oor;
    logic [IW-1:0]       w_dir_idx;
    logic                w_dir_hit;
    logic                w_any_hit;
    logic [IW-1:0]       w_hit_idx;
    logic                w_any_inv;
    logic [IW-1:0]       w_inv_idx;
    logic                w_lk_hit;
    logic [IW-1:0]       w_lk_idx;

    always_comb begin
        w_oor     = ({1'b0, r_addr} >= (ADDR_W+1)'(MEM_DEPTH));
        w_dir_idx = w_mod_tab[r_addr[AW-1:0]];
        w_dir_hit = r_valid[w_dir_idx] && (r_tag[w_dir_idx] == r_addr);
        w_any_hit = 1'b0;
        w_hit_idx = '0;
        w_any_inv = 1'b0;
        w_inv_idx = '0;
        for (int i = LINES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == r_addr)) begin
                w_any_hit = 1'b1;
                w_hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                w_any_inv = 1'b1;
                w_inv_idx = IW'(i);
            end
        end
        if (r_mode == MODE_DIRECT) begin
            w_lk_hit = w_dir_hit;
            w_lk_idx = w_dir_idx;
        end else begin
            w_lk_hit = w_any_hit;
            w_lk_idx = w_any_hit ? w_hit_idx : w_inv_idx;
        end
    end

    assign o_sts.need_scan = (r_mode == MODE_ASSOC) && !w_oor && !w_any_hit && !w_any_inv;
    assign o_sts.scan_last = (r_cnt == IW'(LINES - 1));
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    // commit values
    logic [WORD_W-1:0]   w_fill;
    logic [WORD_W-1:0]   w_line_rd;
    logic [COUNT_W-1:0]  w_use_nx;
    logic [COUNT_W-1:0]  w_hits_nx;
    logic [COUNT_W-1:0]  w_miss_nx;

    always_comb begin
        w_fill    = r_written[r_addr[AW-1:0]] ? w_mem_rdata
                                              : WORD_W'(r_addr) * WORD_W'(10);
        w_line_rd = r_hit ? r_word[r_idx] : w_fill;
        w_use_nx  = r_use + COUNT_W'(1);
        w_hits_nx = r_hits + COUNT_W'(r_hit);
        w_miss_nx = r_misses + COUNT_W'(!r_hit);
    end

    assign w_mem_we = i_cmd.commit && !r_oor && (r_type == REQ_STORE);

    cdla_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MEM_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(r_addr[AW-1:0]),
        .i_wdata(r_value),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(w_mem_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DIRECT;
            r_use       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_written   <= '0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mode   <= i_cfg_mode;
                r_use    <= '0;
                r_hits   <= '0;
                r_misses <= '0;
                for (int i = 0; i < LINES; i++) begin
                    r_valid[i] <= 1'b0;
                end
            end else if (i_cmd.commit && !r_oor) begin
                r_use    <= w_use_nx;
                r_hits   <= w_hits_nx;
                r_misses <= w_miss_nx;
                if (!r_hit) begin
                    r_valid[r_idx] <= 1'b1;
                end
            end
            if (w_mem_we) begin
                r_written[r_addr[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.commit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_addr  <= i_address;
            r_value <= i_store_value;
        end
        if (i_cmd.look) begin
            r_oor <= w_oor;
            r_hit <= w_lk_hit;
            r_idx <= w_lk_idx;
            r_cnt <= '0;
        end
        if (i_cmd.scan) begin
            if ((r_cnt == '0) || (r_stamp[r_cnt] < r_best)) begin
                r_best <= r_stamp[r_cnt];
                r_idx  <= r_cnt;
            end
            r_cnt <= r_cnt + IW'(1);
        end
        if (i_cmd.commit) begin
            if (!r_oor) begin
                r_stamp[r_idx] <= w_use_nx;
                if (!r_hit) begin
                    r_tag[r_idx] <= r_addr;
                end
                if (r_type == REQ_STORE) begin
                    r_word[r_idx] <= r_value;
                end else if (!r_hit) begin
                    r_word[r_idx] <= w_fill;
                end
            end
            if (r_oor) begin
                o_read_data  <= '0;
                o_hit        <= 1'b0;
                o_status     <= STATUS_OOR;
                o_line_used  <= '0;
                o_hit_count  <= r_hits;
                o_miss_count <= r_misses;
            end else begin
                o_read_data  <= (r_type == REQ_STORE) ? '0 : w_line_rd;
                o_hit        <= r_hit;
                o_status     <= STATUS_OK;
                o_line_used  <= LUSED_W'(r_idx);
                o_hit_count  <= w_hits_nx;
                o_miss_count <= w_miss_nx;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/cache_direct_or_lru_assoc.sv
// ----------------------------------------------------------------------------
// cache_direct_or_lru_assoc
// small write-through word cache, direct mapped or fully associative lru
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: tdata holds address and store value, tuser the
//   request kind (load or store). m_axis carries one result item for every
//   request: read data, line used and the hit and miss totals in tdata, the
//   hit flag and the range-error status in tuser
//   i_cfg_we with i_cfg_data writes the mapping mode (0 direct, 1 lru); any
//   write invalidates all lines and clears the use, hit and miss counters,
//   the backing memory keeps its contents. write only while no item is open
// timing
//   one item at a time: accept, lookup, commit. the result is registered at
//   commit and the next item can be taken in the cycle after commit. an
//   associative miss with every line valid adds an lru scan before commit,
//   one stamp per cycle
// reset
//   i_rst_n (synchronous, active low) empties the cache, zeroes the counters,
//   selects direct mode and returns the backing memory to address times ten
//   through per-entry written flags
// back-pressure
//   the result register holds while m_axis_tready is low; a new request is
//   still accepted and runs up to its commit, which waits for the register
// ----------------------------------------------------------------------------
`default_nettype none

module cache_direct_or_lru_assoc
    import cdla_pkg::*;
#(
    parameter int LINES     = 4,
    parameter int MEM_DEPTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_data,     // mapping_mode
    // requests
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,   // address[7:0], store_value[39:8]
    input  wire logic [0:0]   s_axis_tuser,   // req_type
    // results
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // read_data[31:0], line_used[33:32],
                                              // hit_count[65:34], miss_count[97:66],
                                              // zero fill[103:98]
    output logic [1:0]        m_axis_tuser    // hit[0], status[1]
);

    t_cmd w_cmd;
    t_sts w_sts;

    logic [WORD_W-1:0]  w_read_data;
    logic               w_hit;
    logic               w_status;
    logic [LUSED_W-1:0] w_line_used;
    logic [COUNT_W-1:0] w_hit_count;
    logic [COUNT_W-1:0] w_miss_count;

    // sequencer
    cdla_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // lines, counters, backing memory and result register
    cdla_dp #(
        .LINES    (LINES),
        .MEM_DEPTH(MEM_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_mode   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req_type   (s_axis_tuser[0]),
        .i_address    (s_axis_tdata[7:0]),
        .i_store_value(s_axis_tdata[39:8]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_read_data  (w_read_data),
        .o_hit        (w_hit),
        .o_status     (w_status),
        .o_line_used  (w_line_used),
        .o_hit_count  (w_hit_count),
        .o_miss_count (w_miss_count)
    );

    // result packing, highest field first
    assign m_axis_tdata = {6'b0, w_miss_count, w_hit_count, w_line_used, w_read_data};
    assign m_axis_tuser = {w_status, w_hit};

endmodule

`default_nettype wire

>>> sim/tb_cache_direct_or_lru_assoc.sv
// ----------------------------------------------------------------------------
// tb_cache_direct_or_lru_assoc
// self-checking bench for the write-through word cache in both mapping modes
// ----------------------------------------------------------------------------
// requests go in on s_axis in random bursts while m_axis stalls on a pattern
// of its own. a cycle-free model of the cache predicts every result item from
// the accepted requests, and each result is compared field by field with the
// oldest prediction. directed items cover conflicts, write-allocate stores,
// out-of-range addresses and lru victim choice; random phases then switch the
// mapping mode, and one stretch holds the result side off to fill the block
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cache_direct_or_lru_assoc
    import cdla_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES          = 4;
    localparam int MEM_DEPTH      = 16;
    localparam int MEM_AW         = $clog2(MEM_DEPTH);
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 10;    // extra wait after the last result item
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item on either side
    localparam int MAX_REPORTS    = 30;

    // one expected result item
    typedef struct packed {
        logic [WORD_W-1:0]  read_data;
        logic               hit;
        logic               status;
        logic [LUSED_W-1:0] line_used;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
    } t_cache_result;

    // receiver stall styles, re-chosen every so often
    typedef enum int {RX_FREE, RX_COIN, RX_PATTERN, RX_SPARSE} t_rx_style;

    // dut ports, inputs all known from time zero
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic         i_cfg_data    = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata  = '0;  // address[7:0], store_value[39:8]
    logic [0:0]   s_axis_tuser  = '0;  // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;        // read_data, line_used, hit_count, miss_count
    logic [1:0]   m_axis_tuser;        // hit[0], status[1]

    // cache model state
    logic               map_mode;
    logic               line_ok   [LINES];
    logic [ADDR_W-1:0]  line_addr [LINES];
    logic [WORD_W-1:0]  line_data [LINES];
    logic [WORD_W-1:0]  line_age  [LINES];
    logic [WORD_W-1:0]  memory_image [MEM_DEPTH];
    logic [COUNT_W-1:0] access_stamp;
    logic [COUNT_W-1:0] hits_seen;
    logic [COUNT_W-1:0] misses_seen;

    t_cache_result pending_results[$];
    t_cache_result want_result;
    int unsigned   mismatch_count = 0;

    // sender burst control
    int unsigned burst_left    = 0;
    bit          steady_sender = 1'b0;

    // receiver state, owned by the receiver process apart from hold_asked
    int unsigned hold_asked = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left  = 0;
    int unsigned rx_cycle   = 0;
    t_rx_style   rx_style   = RX_FREE;
    logic [7:0]  rx_pattern = 8'hff;

    int unsigned idle_cycles = 0;

    cache_direct_or_lru_assoc #(
        .LINES     (LINES),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // empties every line and clears the counters, memory stays
    function automatic void flush_lines();
        for (int i = 0; i < LINES; i++) begin
            line_ok[i]   = 1'b0;
            line_addr[i] = '0;
            line_data[i] = '0;
            line_age[i]  = '0;
        end
        access_stamp = '0;
        hits_seen    = '0;
        misses_seen  = '0;
    endfunction

    // one access against the model: updates its state, returns the result item
    function automatic t_cache_result predict_access(input logic kind,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [WORD_W-1:0] value);
        t_cache_result     r;
        int unsigned       idx;
        int unsigned       victim;
        logic [WORD_W-1:0] oldest;
        logic              found;
        logic              placed;
        logic              have_oldest;
        r             = '0;
        r.hit_count   = hits_seen;
        r.miss_count  = misses_seen;
        if (addr >= MEM_DEPTH) begin
            // out of range: error only, nothing moves
            r.status = STATUS_OOR;
            return r;
        end
        found       = 1'b0;
        placed      = 1'b0;
        have_oldest = 1'b0;
        victim      = 0;
        oldest      = '0;
        idx         = 0;
        if (map_mode == MODE_DIRECT) begin
            idx   = addr % LINES;
            found = line_ok[idx] && (line_addr[idx] == addr);
        end else begin
            for (int i = 0; i < LINES; i++) begin
                if (!found && line_ok[i] && (line_addr[i] == addr)) begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (!found) begin
                // first invalid line, else smallest stamp with lowest index on a tie
                for (int i = 0; i < LINES; i++) begin
                    if (!placed) begin
                        if (!line_ok[i]) begin
                            idx    = i;
                            placed = 1'b1;
                        end else if (!have_oldest || line_age[i] < oldest) begin
                            oldest      = line_age[i];
                            victim      = i;
                            have_oldest = 1'b1;
                        end
                    end
                end
                if (!placed) idx = victim;
            end
        end
        if (!found) begin
            line_ok[idx]   = 1'b1;
            line_addr[idx] = addr;
            line_data[idx] = memory_image[addr[MEM_AW-1:0]];
        end
        access_stamp   = access_stamp + 1;
        line_age[idx]  = access_stamp;
        if (found) hits_seen = hits_seen + 1;
        else misses_seen = misses_seen + 1;
        if (kind == REQ_STORE) begin
            // write-through after allocation
            line_data[idx]                  = value;
            memory_image[addr[MEM_AW-1:0]] = value;
        end else begin
            r.read_data = line_data[idx];
        end
        r.hit        = found;
        r.status     = STATUS_OK;
        r.line_used  = LUSED_W'(idx);
        r.hit_count  = hits_seen;
        r.miss_count = misses_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // offers one request, in bursts with random gaps, and records its prediction
    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                                input logic [WORD_W-1:0] value);
        int unsigned gap;
        if (!steady_sender && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, addr};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_access(kind, addr, value));
    endtask

    // stops offering and waits for every outstanding result item
    task automatic finish_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode write, only with the block idle; it also flushes the cache
    task automatic apply_mode(input logic mode);
        finish_traffic();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        map_mode = mode;
        flush_lines();
    endtask

    // conflicts on one line, write-allocate stores, range errors, extreme values
    task automatic test_direct_mapping();
        apply_mode(MODE_DIRECT);
        send_request(REQ_LOAD,  8'd0,   32'h0000_0000);  // cold miss
        send_request(REQ_LOAD,  8'd4,   32'hffff_ffff);  // same line, evicts 0
        send_request(REQ_LOAD,  8'd0,   32'h0000_0000);  // miss again
        send_request(REQ_LOAD,  8'd0,   32'h0000_0000);  // hit
        send_request(REQ_STORE, 8'd5,   32'h8000_0000);  // store miss allocates
        send_request(REQ_LOAD,  8'd5,   32'h0000_0000);  // reads the stored word
        send_request(REQ_STORE, 8'd5,   32'h7fff_ffff);  // store hit
        send_request(REQ_LOAD,  8'd15,  32'h0000_0000);  // top of memory
        send_request(REQ_LOAD,  8'd16,  32'h0000_0000);  // first address out of range
        send_request(REQ_STORE, 8'd255, 32'hffff_ffff);  // store out of range
        send_request(REQ_LOAD,  8'd4,   32'h0000_0000);  // memory kept the old value
    endtask

    // fill order by invalid lines, then least recently used victims
    task automatic test_lru_replacement();
        apply_mode(MODE_ASSOC);
        send_request(REQ_LOAD,  8'd5,  32'h0);  // memory survived the flush
        send_request(REQ_LOAD,  8'd1,  32'h0);
        send_request(REQ_LOAD,  8'd2,  32'h0);
        send_request(REQ_LOAD,  8'd3,  32'h0);  // all lines valid now
        send_request(REQ_LOAD,  8'd5,  32'h0);  // hit, refreshes its stamp
        send_request(REQ_LOAD,  8'd9,  32'h0);  // evicts 1
        send_request(REQ_LOAD,  8'd1,  32'h0);  // evicts 2
        send_request(REQ_STORE, 8'd13, 32'h1234_5678);
        send_request(REQ_LOAD,  8'd13, 32'h0);
        send_request(REQ_LOAD,  8'd200, 32'h0);
    endtask

    // result side held off while requests keep coming, input must stall
    task automatic test_backpressure();
        apply_mode(MODE_ASSOC);
        steady_sender = 1'b1;
        hold_asked++;
        @(posedge i_clk);
        for (int n = 0; n < 24; n++)
            send_request(($urandom_range(0, 1) == 1) ? REQ_STORE : REQ_LOAD,
                         ADDR_W'($urandom_range(0, MEM_DEPTH - 1)), $urandom);
        steady_sender = 1'b0;
    endtask

    // mostly a hot set of addresses so that hits and evictions both happen
    task automatic test_random_traffic(input logic mode, input int unsigned count,
                                       input bit no_gaps);
        logic [ADDR_W-1:0] hot_set [6];
        logic [ADDR_W-1:0] addr;
        int unsigned       pick;
        apply_mode(mode);
        foreach (hot_set[k]) hot_set[k] = ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
        steady_sender = no_gaps;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) addr = ADDR_W'($urandom_range(MEM_DEPTH, 255));
            else if (pick < 65) addr = hot_set[$urandom_range(0, 5)];
            else addr = ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
            send_request(($urandom_range(0, 99) < 40) ? REQ_STORE : REQ_LOAD, addr, $urandom);
        end
        steady_sender = 1'b0;
    endtask

    // receiver: long hold-off on request, otherwise a changing stall style
    always @(posedge i_clk) begin
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_cycle % 96 == 0) begin
                rx_style   = t_rx_style'($urandom_range(0, 3));
                rx_pattern = 8'($urandom);
            end
            rx_cycle++;
            case (rx_style)
                RX_FREE:    m_axis_tready <= 1'b1;
                RX_COIN:    m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_PATTERN: m_axis_tready <= rx_pattern[3'(rx_cycle)];
                default:    m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result checker, oldest prediction first
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result item", {24'd0, m_axis_tdata[39:0]}, '0);
            end else begin
                want_result = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want_result.read_data)
                    report_mismatch("read_data", 64'(m_axis_tdata[31:0]),
                                    64'(want_result.read_data));
                if (m_axis_tuser[0] !== want_result.hit)
                    report_mismatch("hit", 64'(m_axis_tuser[0]), 64'(want_result.hit));
                if (m_axis_tuser[1] !== want_result.status)
                    report_mismatch("status", 64'(m_axis_tuser[1]), 64'(want_result.status));
                if (m_axis_tdata[33:32] !== want_result.line_used)
                    report_mismatch("line_used", 64'(m_axis_tdata[33:32]),
                                    64'(want_result.line_used));
                if (m_axis_tdata[65:34] !== want_result.hit_count)
                    report_mismatch("hit_count", 64'(m_axis_tdata[65:34]),
                                    64'(want_result.hit_count));
                if (m_axis_tdata[97:66] !== want_result.miss_count)
                    report_mismatch("miss_count", 64'(m_axis_tdata[97:66]),
                                    64'(want_result.miss_count));
            end
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        // model starts in the reset state, memory holds address times ten
        map_mode = MODE_DIRECT;
        flush_lines();
        for (int i = 0; i < MEM_DEPTH; i++) memory_image[i] = WORD_W'(i * 10);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_direct_mapping();
        test_lru_replacement();
        test_backpressure();
        test_random_traffic(MODE_DIRECT, 200, 1'b0);
        test_random_traffic(MODE_ASSOC,  250, 1'b0);
        test_random_traffic(MODE_ASSOC,  200, 1'b1);
        test_random_traffic(MODE_DIRECT, 150, 1'b0);
        test_random_traffic(MODE_ASSOC,  200, 1'b0);
        finish_traffic();

        if (pending_results.size() != 0)
            report_mismatch("results left over", 64'(pending_results.size()), '0);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
